@@ sv/video_bus_registers_with_beam_firq_macros.svh @@
// ----------------------------------------------------------------------------
// video bus registers assertion macros
// shared assertion wrappers on clk_i and rst_ni
// ----------------------------------------------------------------------------
`ifndef VIDEO_BUS_REGISTERS_WITH_BEAM_FIRQ_MACROS_SVH
`define VIDEO_BUS_REGISTERS_WITH_BEAM_FIRQ_MACROS_SVH

// checked only while out of reset
`define VBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every edge, reset included
`define VBR_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

@@ sv/vbr_pkg.sv @@
// ----------------------------------------------------------------------------
// vbr_pkg
// geometry constants, command codes and address helpers of the video bus block
// ----------------------------------------------------------------------------
package vbr_pkg;

  // memory geometry
  localparam int ROW_COUNT  = 256;
  localparam int ROW_BYTES  = 256;
  localparam int BANK_BYTES = 512;

  localparam int VMEM_SIZE = ROW_COUNT * ROW_BYTES;
  localparam int PMEM_SIZE = 2 * BANK_BYTES;
  localparam int VA        = $clog2(VMEM_SIZE);
  localparam int PA        = $clog2(PMEM_SIZE);
  localparam int OA        = $clog2(BANK_BYTES);
  localparam int RMW       = $clog2(ROW_COUNT);
  localparam int LINW      = $clog2(VMEM_SIZE + 512);

  // clearing pass covers the larger memory
  localparam int CLR_LEN = (VMEM_SIZE > PMEM_SIZE) ? VMEM_SIZE : PMEM_SIZE;
  localparam int CW      = $clog2(CLR_LEN);

  // command codes
  typedef enum logic [3:0] {
    CMD_VRAM_RD  = 4'd0,
    CMD_VRAM_WR  = 4'd1,
    CMD_PAL_RD   = 4'd2,
    CMD_PAL_WR   = 4'd3,
    CMD_CTRL_WR  = 4'd4,
    CMD_VBL_CLR  = 4'd5,
    CMD_HPOS_RD  = 4'd6,
    CMD_VPOS_RD  = 4'd7,
    CMD_VBLANK   = 4'd8,
    CMD_BEAM     = 4'd9,
    CMD_COLLIDE  = 4'd10,
    CMD_LOOKUP   = 4'd11
  } cmd_e;

  // where a result's data comes from
  typedef enum logic [1:0] {
    SRC_IMM,
    SRC_VRAM,
    SRC_PAL,
    SRC_LOOKUP
  } rd_src_e;

  // row number folded into the row count
  typedef logic [RMW-1:0] row_lut_t [256];
  // low address byte folded into the bank size
  typedef logic [OA-1:0] bank_lut_t [256];

  function automatic row_lut_t build_row_lut();
    row_lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = RMW'(i % ROW_COUNT);
    end
    return t;
  endfunction

  function automatic bank_lut_t build_bank_lut();
    bank_lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = OA'(i % BANK_BYTES);
    end
    return t;
  endfunction

  localparam row_lut_t  ROW_MOD_LUT  = build_row_lut();
  localparam bank_lut_t BANK_MOD_LUT = build_bank_lut();
  localparam logic [OA-1:0] HIGH_TERM = OA'(256 % BANK_BYTES);

  // linear video index, wrapped at the memory size
  function automatic logic [VA-1:0] vram_index(input logic [7:0] row,
                                               input logic [8:0] addr);
    logic [LINW-1:0] lin;
    lin = LINW'(ROW_MOD_LUT[row]) * LINW'(ROW_BYTES) + LINW'(addr);
    if (lin >= LINW'(VMEM_SIZE)) lin = lin - LINW'(VMEM_SIZE);
    if (lin >= LINW'(VMEM_SIZE)) lin = lin - LINW'(VMEM_SIZE);
    return lin[VA-1:0];
  endfunction

  // 9-bit offset folded into one palette bank
  function automatic logic [OA-1:0] bank_offset(input logic [8:0] a);
    logic [OA:0] s;
    s = {1'b0, BANK_MOD_LUT[a[7:0]]} + (a[8] ? {1'b0, HIGH_TERM} : '0);
    if (s >= (OA+1)'(BANK_BYTES)) s = s - (OA+1)'(BANK_BYTES);
    return s[OA-1:0];
  endfunction

  // bank select plus offset
  function automatic logic [PA-1:0] pal_index(input logic bank, input logic [OA-1:0] off);
    return bank ? (PA'(BANK_BYTES) + PA'(off)) : PA'(off);
  endfunction

endpackage

@@ sv/vbr_if.sv @@
// ----------------------------------------------------------------------------
// vbr channel interfaces
// valid/ready channels for bus items and result items
// ----------------------------------------------------------------------------
interface vbr_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] cmd;
  logic [7:0] vram_row;
  logic [8:0] address;
  logic [7:0] wdata;
  logic [8:0] beam_x;
  logic [8:0] scanline_now;
  logic [7:0] pen;

  modport source (output valid, cmd, vram_row, address, wdata, beam_x, scanline_now, pen,
                  input ready);
  modport sink   (input valid, cmd, vram_row, address, wdata, beam_x, scanline_now, pen,
                  output ready);
endinterface

interface vbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       firq;
  logic [3:0] cpu_bank;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       collide_flag;

  modport source (output valid, read_data, firq, cpu_bank, red, green, blue, collide_flag,
                  input ready);
  modport sink   (input valid, read_data, firq, cpu_bank, red, green, blue, collide_flag,
                  output ready);
endinterface

@@ sv/video_bus_registers_with_beam_firq.sv @@
// ----------------------------------------------------------------------------
// video_bus_registers_with_beam_firq
// cpu-side video controller: video ram, palette banks, control and firq flags
// ----------------------------------------------------------------------------
// pipeline: an item passes stage one, then the output register
// throughput: one item per cycle unless the output stalls; a colour lookup holds
//   off the input while its second palette byte uses the shared palette read port
// reset: flags and control clear at once, then a clearing pass writes zero to
//   both memories, one entry a cycle over CLR_LEN (65536) entries, no item taken
`include "video_bus_registers_with_beam_firq_macros.svh"

module video_bus_registers_with_beam_firq
  import vbr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  vbr_in_if.sink   in_i,
  vbr_out_if.source out_o
);

  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_LEN - 1);

  // clearing pass
  logic          clr_active_q;
  logic [CW-1:0] clr_cnt_q;

  // control and flag registers
  logic [3:0] bank_q, bank_d;
  logic       irq_en_q, irq_en_d;
  logic       irq_sel_q, irq_sel_d;
  logic       io_bank_q, io_bank_d;
  logic       vis_bank_q, vis_bank_d;
  logic       vblank_q, vblank_d;
  logic       beam_q, beam_d;
  logic [7:0] latched_q, latched_d;

  // stage one: item waiting on ram data
  logic          s1_v_q, s1_ph0_q;
  rd_src_e       s1_src_q, src_d;
  logic [7:0]    s1_imm_q, imm_d;
  logic          s1_firq_q;
  logic [3:0]    s1_bank_q;
  logic [PA-1:0] s1_lo_idx_q;
  logic [7:0]    s1_hi_q;

  // output register
  logic       out_v_q;
  logic [7:0] out_rd_q, out_r_q, out_g_q, out_b_q;
  logic       out_firq_q, out_col_q;
  logic [3:0] out_bank_q;

  // handshake
  logic in_acc, out_free, s1_adv, ph0_tick;
  cmd_e cmd;

  // memory ports
  logic          vram_we_acc, vram_we, vram_re;
  logic [VA-1:0] vram_idx, vram_waddr;
  logic [7:0]    vram_wdata, vram_rdata;
  logic          pal_we_acc, pal_we, pal_re, pal_re_acc;
  logic [PA-1:0] pal_waddr, pal_raddr, pal_raddr_acc;
  logic [7:0]    pal_wdata, pal_rdata;

  // address and event helpers
  logic [PA-1:0] io_idx, vis_hi_idx, vis_lo_idx;
  logic [OA-1:0] hi_off, lo_off;
  logic [9:0]    x_inc;
  logic [8:0]    x_half;
  logic [7:0]    latch_val, vpos_val;
  logic [7:0]    out_rd_d;

  assign cmd      = cmd_e'(in_i.cmd);
  assign out_free = !out_v_q || out_o.ready;
  assign ph0_tick = s1_v_q && s1_ph0_q;
  assign s1_adv   = s1_v_q && !s1_ph0_q && out_free;
  assign in_i.ready = !clr_active_q && (!s1_v_q || s1_adv);
  assign in_acc   = in_i.valid && in_i.ready;

  // address arithmetic
  assign vram_idx   = vram_index(in_i.vram_row, in_i.address);
  assign io_idx     = pal_index(io_bank_q, bank_offset(in_i.address));
  assign hi_off     = bank_offset({in_i.pen, 1'b0});
  assign lo_off     = (hi_off == OA'(BANK_BYTES - 1)) ? '0 : hi_off + OA'(1);
  assign vis_hi_idx = pal_index(vis_bank_q, hi_off);
  assign vis_lo_idx = pal_index(vis_bank_q, lo_off);

  // beam position latch and vertical saturation
  assign x_inc     = {1'b0, in_i.beam_x} + 10'd1;
  assign x_half    = x_inc[9:1];
  assign latch_val = (x_half[7:0] + 8'd3) ^ 8'd2;
  assign vpos_val  = (in_i.scanline_now >= 9'd255) ? 8'hff : in_i.scanline_now[7:0];

  // command decode and register next state
  always_comb begin
    bank_d        = bank_q;
    irq_en_d      = irq_en_q;
    irq_sel_d     = irq_sel_q;
    io_bank_d     = io_bank_q;
    vis_bank_d    = vis_bank_q;
    vblank_d      = vblank_q;
    beam_d        = beam_q;
    latched_d     = latched_q;
    src_d         = SRC_IMM;
    imm_d         = '0;
    vram_we_acc   = 1'b0;
    vram_re       = 1'b0;
    pal_we_acc    = 1'b0;
    pal_re_acc    = 1'b0;
    pal_raddr_acc = io_idx;
    if (in_acc) begin
      unique case (cmd)
        CMD_VRAM_RD: begin
          vram_re = 1'b1;
          src_d   = SRC_VRAM;
        end
        CMD_VRAM_WR: vram_we_acc = 1'b1;
        CMD_PAL_RD: begin
          pal_re_acc = 1'b1;
          src_d      = SRC_PAL;
        end
        CMD_PAL_WR: pal_we_acc = 1'b1;
        CMD_CTRL_WR: begin
          bank_d     = in_i.wdata[7:4];
          irq_en_d   = in_i.wdata[3];
          irq_sel_d  = in_i.wdata[2];
          io_bank_d  = in_i.wdata[1];
          vis_bank_d = in_i.wdata[0];
        end
        CMD_VBL_CLR: vblank_d = 1'b0;
        CMD_HPOS_RD: begin
          beam_d = 1'b0;
          imm_d  = latched_q;
        end
        CMD_VPOS_RD: imm_d = vpos_val;
        CMD_VBLANK:  vblank_d = 1'b1;
        CMD_BEAM: begin
          if (irq_sel_q && irq_en_q) beam_d = 1'b1;
          latched_d = latch_val;
        end
        CMD_COLLIDE: begin
          if (!irq_sel_q && irq_en_q) beam_d = 1'b1;
          latched_d = latch_val;
        end
        CMD_LOOKUP: begin
          pal_re_acc    = 1'b1;
          pal_raddr_acc = vis_hi_idx;
          src_d         = SRC_LOOKUP;
        end
        default: ;
      endcase
    end
  end

  // memory port muxing, clearing pass owns the write ports
  assign vram_we    = clr_active_q ? ({1'b0, clr_cnt_q} < (CW+1)'(VMEM_SIZE)) : vram_we_acc;
  assign vram_waddr = clr_active_q ? clr_cnt_q[VA-1:0] : vram_idx;
  assign vram_wdata = clr_active_q ? 8'h00 : in_i.wdata;
  assign pal_we     = clr_active_q ? ({1'b0, clr_cnt_q} < (CW+1)'(PMEM_SIZE)) : pal_we_acc;
  assign pal_waddr  = clr_active_q ? clr_cnt_q[PA-1:0] : io_idx;
  assign pal_wdata  = clr_active_q ? 8'h00 : in_i.wdata;
  assign pal_re     = pal_re_acc || ph0_tick;
  assign pal_raddr  = ph0_tick ? s1_lo_idx_q : pal_raddr_acc;

  vbr_ram #(.WIDTH(8), .DEPTH(VMEM_SIZE)) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .re_i    (vram_re),
    .raddr_i (vram_idx),
    .rdata_o (vram_rdata)
  );

  vbr_ram #(.WIDTH(8), .DEPTH(PMEM_SIZE)) u_pal (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .re_i    (pal_re),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + CW'(1);
      if (clr_cnt_q == CLR_LAST) clr_active_q <= 1'b0;
    end
  end

  // control and flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q     <= '0;
      irq_en_q   <= 1'b0;
      irq_sel_q  <= 1'b0;
      io_bank_q  <= 1'b0;
      vis_bank_q <= 1'b0;
      vblank_q   <= 1'b0;
      beam_q     <= 1'b0;
      latched_q  <= '0;
    end else begin
      bank_q     <= bank_d;
      irq_en_q   <= irq_en_d;
      irq_sel_q  <= irq_sel_d;
      io_bank_q  <= io_bank_d;
      vis_bank_q <= vis_bank_d;
      vblank_q   <= vblank_d;
      beam_q     <= beam_d;
      latched_q  <= latched_d;
    end
  end

  // stage one control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_ph0_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q   <= 1'b1;
        s1_ph0_q <= (cmd == CMD_LOOKUP);
      end else begin
        if (s1_adv) s1_v_q <= 1'b0;
        if (ph0_tick) s1_ph0_q <= 1'b0;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_src_q    <= src_d;
      s1_imm_q    <= imm_d;
      s1_firq_q   <= vblank_d | (irq_en_d & beam_d);
      s1_bank_q   <= bank_d;
      s1_lo_idx_q <= vis_lo_idx;
    end
    if (ph0_tick) s1_hi_q <= pal_rdata;
  end

  // result data select
  always_comb begin
    case (s1_src_q)
      SRC_VRAM: out_rd_d = vram_rdata;
      SRC_PAL:  out_rd_d = pal_rdata;
      SRC_IMM:  out_rd_d = s1_imm_q;
      default:  out_rd_d = '0;
    endcase
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_rd_q   <= out_rd_d;
      out_firq_q <= s1_firq_q;
      out_bank_q <= s1_bank_q;
      if (s1_src_q == SRC_LOOKUP) begin
        out_r_q   <= {s1_hi_q[6:2], 3'b000};
        out_g_q   <= {s1_hi_q[1:0], pal_rdata[7:5], 3'b000};
        out_b_q   <= {pal_rdata[4:0], 3'b000};
        out_col_q <= s1_hi_q[7];
      end else begin
        out_r_q   <= '0;
        out_g_q   <= '0;
        out_b_q   <= '0;
        out_col_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.read_data    = out_rd_q;
  assign out_o.firq         = out_firq_q;
  assign out_o.cpu_bank     = out_bank_q;
  assign out_o.red          = out_r_q;
  assign out_o.green        = out_g_q;
  assign out_o.blue         = out_b_q;
  assign out_o.collide_flag = out_col_q;

  // checks
  `VBR_ASSERT(a_ph0_blocks_input, (s1_v_q && s1_ph0_q) |-> !in_acc, "item taken during lookup")
  `VBR_ASSERT(a_ph0_single_cycle, (s1_v_q && s1_ph0_q) |=> (s1_v_q && !s1_ph0_q), "lookup stuck")
  `VBR_ASSERT(a_clear_no_reads, clr_active_q |-> !(vram_re || pal_re), "read during clear")
  `VBR_ASSERT(a_clear_full_sweep, $fell(clr_active_q) |-> ($past(clr_cnt_q) == CLR_LAST), "short clear")
  `VBR_ASSERT_ANY(a_reset_starts_clear, !rst_ni |-> clr_active_q, "reset without clear")

endmodule

@@ sv/vbr_ram.sv @@
// ----------------------------------------------------------------------------
// vbr_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module vbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/video_bus_registers_with_beam_firq_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_bus_registers_with_beam_firq_test
// drives bus accesses and beam events into the video controller and checks
// every result item against a cycle-free model of the video ram, palette
// banks, control register and firq flags, under several idling patterns
// ----------------------------------------------------------------------------
module video_bus_registers_with_beam_firq_test
  import vbr_pkg::*;
();

  // command codes the block ignores
  localparam logic [3:0] CMD_SPARE_FIRST = 4'd12;
  localparam logic [3:0] CMD_SPARE_LAST  = 4'd15;

  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS = 10;
  localparam int TIMEOUT_NS = 1_000_000;
  localparam int SEND_IDLE  [4] = '{0, 86, 0, 6};
  localparam int RECV_STALL [4] = '{0, 0, 86, 6};

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] vram_row;
    logic [8:0] address;
    logic [7:0] wdata;
    logic [8:0] beam_x;
    logic [8:0] scanline_now;
    logic [7:0] pen;
  } bus_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       firq;
    logic [3:0] cpu_bank;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       collide_flag;
  } bus_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  vbr_in_if  bus_if ();
  vbr_out_if res_if ();

  video_bus_registers_with_beam_firq dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (bus_if),
    .out_o  (res_if)
  );

  always #1 clk_i = ~clk_i;

  // model state of the controller
  logic [7:0] vid_ram [VMEM_SIZE];
  logic [7:0] pal_ram [PMEM_SIZE];
  logic [3:0] cpu_bank_q;
  logic       firq_en, firq_sel, io_bank_sel, vis_bank_sel;
  logic       vblank_pend, beam_pend;
  logic [7:0] hpos_latch;

  bus_item_t   bus_items [$];
  bus_result_t expected_results [$];
  logic [16:0] touched_vram [$];

  int items_offered = 0;
  int items_taken = 0;
  int fail_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // next bus state and result for one accepted item
  function automatic bus_result_t predict_bus_result(bus_item_t it);
    bus_result_t r;
    int          idx, hi_idx, lo_idx;
    logic [9:0]  half;
    logic [15:0] word;
    r = '0;
    case (it.cmd)
      CMD_VRAM_RD: begin
        idx = (int'(it.vram_row) * ROW_BYTES + int'(it.address)) % VMEM_SIZE;
        r.read_data = vid_ram[idx];
      end
      CMD_VRAM_WR: begin
        idx = (int'(it.vram_row) * ROW_BYTES + int'(it.address)) % VMEM_SIZE;
        vid_ram[idx] = it.wdata;
      end
      CMD_PAL_RD: begin
        r.read_data = pal_ram[int'(io_bank_sel) * BANK_BYTES + int'(it.address) % BANK_BYTES];
      end
      CMD_PAL_WR: begin
        pal_ram[int'(io_bank_sel) * BANK_BYTES + int'(it.address) % BANK_BYTES] = it.wdata;
      end
      CMD_CTRL_WR: begin
        {cpu_bank_q, firq_en, firq_sel, io_bank_sel, vis_bank_sel} = it.wdata;
      end
      CMD_VBL_CLR: vblank_pend = 1'b0;
      CMD_HPOS_RD: begin
        beam_pend = 1'b0;
        r.read_data = hpos_latch;
      end
      CMD_VPOS_RD: r.read_data = (it.scanline_now < 9'd255) ? it.scanline_now[7:0] : 8'hFF;
      CMD_VBLANK: vblank_pend = 1'b1;
      CMD_BEAM, CMD_COLLIDE: begin
        // beam wants select set, collision wants it clear
        if (firq_en && (firq_sel == (it.cmd == CMD_BEAM))) beam_pend = 1'b1;
        half = ({1'b0, it.beam_x} + 10'd1) >> 1;
        hpos_latch = 8'((half + 10'd3) ^ 10'd2);
      end
      CMD_LOOKUP: begin
        hi_idx = int'(vis_bank_sel) * BANK_BYTES + (2 * int'(it.pen)) % BANK_BYTES;
        lo_idx = int'(vis_bank_sel) * BANK_BYTES + (2 * int'(it.pen) + 1) % BANK_BYTES;
        word = {pal_ram[hi_idx], pal_ram[lo_idx]};
        r.red = {word[14:10], 3'b000};
        r.green = {word[9:5], 3'b000};
        r.blue = {word[4:0], 3'b000};
        r.collide_flag = word[15];
      end
      default: ;
    endcase
    r.firq = vblank_pend | (firq_en & beam_pend);
    r.cpu_bank = cpu_bank_q;
    return r;
  endfunction

  task automatic check_bus_result(bus_result_t want, bus_result_t got);
    if (want.read_data !== got.read_data || want.firq !== got.firq ||
        want.cpu_bank !== got.cpu_bank || want.red !== got.red ||
        want.green !== got.green || want.blue !== got.blue ||
        want.collide_flag !== got.collide_flag) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS) begin
        $display("mismatch at %0t: exp rd=%h firq=%b bank=%h rgb=%h/%h/%h col=%b", $realtime,
                 want.read_data, want.firq, want.cpu_bank, want.red, want.green, want.blue,
                 want.collide_flag);
        $display("                  got rd=%h firq=%b bank=%h rgb=%h/%h/%h col=%b",
                 got.read_data, got.firq, got.cpu_bank, got.red, got.green, got.blue,
                 got.collide_flag);
      end
    end
  endtask

  // item driver, one offer at a time
  always @(negedge clk_i) begin
    bus_item_t cur;
    if (!rst_ni) begin
      bus_if.valid <= 1'b0;
    end else if (items_offered == items_taken) begin
      if (bus_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur = bus_items.pop_front();
        bus_if.cmd <= cur.cmd;
        bus_if.vram_row <= cur.vram_row;
        bus_if.address <= cur.address;
        bus_if.wdata <= cur.wdata;
        bus_if.beam_x <= cur.beam_x;
        bus_if.scanline_now <= cur.scanline_now;
        bus_if.pen <= cur.pen;
        bus_if.valid <= 1'b1;
        items_offered++;
      end else begin
        bus_if.valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accept, compare on result
  always @(posedge clk_i) begin
    bus_item_t   seen;
    bus_result_t got;
    if (rst_ni) begin
      if (bus_if.valid && bus_if.ready) begin
        seen = {bus_if.cmd, bus_if.vram_row, bus_if.address, bus_if.wdata, bus_if.beam_x,
                bus_if.scanline_now, bus_if.pen};
        expected_results.push_back(predict_bus_result(seen));
        items_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        got = {res_if.read_data, res_if.firq, res_if.cpu_bank, res_if.red, res_if.green,
               res_if.blue, res_if.collide_flag};
        if (expected_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) $display("unexpected result item at %0t", $realtime);
        end else begin
          check_bus_result(expected_results.pop_front(), got);
        end
      end
    end
  end

  function automatic bus_item_t rand_bus_item(logic [3:0] c);
    bus_item_t it;
    it.cmd = c;
    it.vram_row = 8'($urandom);
    it.address = 9'($urandom);
    it.wdata = 8'($urandom);
    it.beam_x = 9'($urandom);
    it.scanline_now = 9'($urandom);
    it.pen = 8'($urandom);
    return it;
  endfunction

  // directed item; pos feeds both the beam x and the scanline
  task automatic put_item(logic [3:0] c, logic [7:0] row, logic [8:0] addr, logic [7:0] data,
                          logic [8:0] pos, logic [7:0] pen);
    bus_items.push_back('{c, row, addr, data, pos, pos, pen});
  endtask

  function automatic logic [7:0] pick_row();
    case ($urandom_range(4))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hFE;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [8:0] pick_addr();
    case ($urandom_range(5))
      0: return 9'h000;
      1: return 9'h001;
      2: return 9'h0FF;
      3: return 9'h100;
      4: return 9'h1FF;
      default: return 9'($urandom);
    endcase
  endfunction

  // one short random sequence, mostly well formed
  task automatic queue_random_burst(inout int made);
    bus_item_t it;
    int        sel;
    logic [7:0] pen;
    sel = $urandom_range(99);
    if (sel < 30) begin
      // video write then a read, usually somewhere recently written
      it = rand_bus_item(CMD_VRAM_WR);
      it.vram_row = pick_row();
      it.address = pick_addr();
      bus_items.push_back(it);
      touched_vram.push_back({it.vram_row, it.address});
      if (touched_vram.size() > 16) void'(touched_vram.pop_front());
      it = rand_bus_item(CMD_VRAM_RD);
      if ($urandom_range(3) != 0)
        {it.vram_row, it.address} = touched_vram[$urandom_range(touched_vram.size() - 1)];
      bus_items.push_back(it);
      made += 2;
    end else if (sel < 50) begin
      // palette word for one pen, then a lookup or read of it
      pen = 8'($urandom);
      it = rand_bus_item(CMD_PAL_WR);
      it.address = {pen, 1'b0};
      bus_items.push_back(it);
      it = rand_bus_item(CMD_PAL_WR);
      it.address = {pen, 1'b1};
      bus_items.push_back(it);
      it = rand_bus_item($urandom_range(1) ? CMD_LOOKUP : CMD_PAL_RD);
      it.pen = pen;
      it.address = {pen, 1'($urandom)};
      bus_items.push_back(it);
      made += 3;
    end else if (sel < 62) begin
      it = rand_bus_item(CMD_CTRL_WR);
      if ($urandom_range(1)) it.wdata[3] = 1'b1;
      bus_items.push_back(it);
      made++;
    end else if (sel < 78) begin
      // beam side event, usually followed by the position read
      bus_items.push_back(rand_bus_item($urandom_range(1) ? CMD_BEAM : CMD_COLLIDE));
      made++;
      if ($urandom_range(3) != 0) begin
        bus_items.push_back(rand_bus_item(CMD_HPOS_RD));
        made++;
      end
    end else if (sel < 90) begin
      case ($urandom_range(3))
        0: it = rand_bus_item(CMD_VBLANK);
        1: it = rand_bus_item(CMD_VBL_CLR);
        2: it = rand_bus_item(CMD_VPOS_RD);
        default: it = rand_bus_item(CMD_HPOS_RD);
      endcase
      bus_items.push_back(it);
      made++;
    end else begin
      bus_items.push_back(rand_bus_item(4'($urandom_range(CMD_SPARE_LAST))));
      made++;
    end
  endtask

  // sender pause until every pending result is back
  task automatic wait_for_results();
    while (bus_items.size() != 0 || items_offered != items_taken ||
           expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    int made;
    rst_ni = 1'b1;
    bus_if.valid = 1'b0;
    bus_if.cmd = CMD_VRAM_RD;
    bus_if.vram_row = '0;
    bus_if.address = '0;
    bus_if.wdata = '0;
    bus_if.beam_x = '0;
    bus_if.scanline_now = '0;
    bus_if.pen = '0;
    res_if.ready = 1'b0;
    foreach (vid_ram[i]) vid_ram[i] = '0;
    foreach (pal_ram[i]) pal_ram[i] = '0;
    {cpu_bank_q, firq_en, firq_sel, io_bank_sel, vis_bank_sel} = '0;
    {vblank_pend, beam_pend, hpos_latch} = '0;

    // reset edge after time zero so every flop sees it
    #0.5 rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // video address past the last row wraps, offset past a row spills over
    put_item(CMD_VRAM_WR, 8'hFF, 9'h1FF, 8'hFF, 9'h000, 8'h00);
    put_item(CMD_VRAM_RD, 8'h00, 9'h0FF, 8'h00, 9'h000, 8'h00);
    put_item(CMD_VRAM_WR, 8'h80, 9'h100, 8'h5A, 9'h1FF, 8'hFF);
    put_item(CMD_VRAM_RD, 8'h81, 9'h000, 8'h00, 9'h000, 8'h00);
    put_item(CMD_PAL_WR, 8'h00, 9'h1FF, 8'hC3, 9'h000, 8'h00);
    put_item(CMD_PAL_RD, 8'h00, 9'h1FF, 8'h00, 9'h000, 8'h00);
    // all control bits set: io and visible bank 1, beam selects the firq
    put_item(CMD_CTRL_WR, 8'h00, 9'h000, 8'hFF, 9'h000, 8'h00);
    put_item(CMD_PAL_RD, 8'h00, 9'h1FF, 8'h00, 9'h000, 8'h00);
    put_item(CMD_PAL_WR, 8'h00, 9'h000, 8'hFF, 9'h000, 8'h00);
    put_item(CMD_PAL_WR, 8'h00, 9'h001, 8'hFF, 9'h000, 8'h00);
    put_item(CMD_PAL_WR, 8'h00, 9'h1FE, 8'h80, 9'h000, 8'h00);
    put_item(CMD_LOOKUP, 8'h00, 9'h000, 8'h00, 9'h000, 8'h00);
    put_item(CMD_LOOKUP, 8'h00, 9'h000, 8'h00, 9'h000, 8'hFF);
    // beam raises the flag, collision does not, position read clears
    put_item(CMD_BEAM, 8'h00, 9'h000, 8'h00, 9'h1FF, 8'h00);
    put_item(CMD_COLLIDE, 8'h00, 9'h000, 8'h00, 9'h000, 8'h00);
    put_item(CMD_HPOS_RD, 8'h00, 9'h000, 8'h00, 9'h000, 8'h00);
    // enable with collision select
    put_item(CMD_CTRL_WR, 8'h00, 9'h000, 8'h08, 9'h000, 8'h00);
    put_item(CMD_COLLIDE, 8'h00, 9'h000, 8'h00, 9'h001, 8'h00);
    put_item(CMD_HPOS_RD, 8'h00, 9'h000, 8'h00, 9'h000, 8'h00);
    // vblank flag and saturating vertical position
    put_item(CMD_VBLANK, 8'h00, 9'h000, 8'h00, 9'h000, 8'h00);
    put_item(CMD_VPOS_RD, 8'h00, 9'h000, 8'h00, 9'h1FF, 8'h00);
    put_item(CMD_VPOS_RD, 8'h00, 9'h000, 8'h00, 9'h0FE, 8'h00);
    put_item(CMD_VBL_CLR, 8'h00, 9'h000, 8'h00, 9'h000, 8'h00);
    put_item(CMD_SPARE_FIRST, 8'hFF, 9'h1FF, 8'hFF, 9'h1FF, 8'hFF);
    put_item(CMD_SPARE_LAST, 8'h00, 9'h000, 8'h00, 9'h000, 8'h00);
    put_item(CMD_CTRL_WR, 8'h00, 9'h000, 8'h00, 9'h000, 8'h00);
    wait_for_results();

    // random phases with different idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      made = 0;
      while (made < PHASE_ITEMS) queue_random_burst(made);
      // long receiver hold while the sender keeps offering
      if (ph == 0) hold_asked++;
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
